### src/el2tk_pkg.sv
// Shared constants, codes and types for the exact L2 top-k search block.
// Used by the channel interfaces, the top-k list and the top level.
package el2tk_pkg;

  localparam int D_MAX    = 128;
  localparam int K_MAX    = 16;
  localparam int MAX_BASE = 1048576;

  localparam int VAL_W      = 16;
  localparam int DIMS_W     = 8;
  localparam int K_W        = 5;
  localparam int POS_W      = $clog2(D_MAX);
  localparam int POS_CMP_W  = POS_W + 1;
  localparam int ID_W       = $clog2(MAX_BASE);
  localparam int CTR_W      = ID_W + 1;
  localparam int DIST_W     = 48;
  localparam int SQ_W       = 2 * VAL_W;
  localparam int CNT_W      = $clog2(K_MAX + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(128);
  localparam logic [K_W-1:0]    K_RESET    = K_W'(10);
  localparam logic [DIMS_W-1:0] DIMS_MAX_C = DIMS_W'(D_MAX);
  localparam logic [K_W-1:0]    K_MAX_C    = K_W'(K_MAX);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(K_MAX);
  localparam logic [CTR_W-1:0]  BASE_LIMIT = CTR_W'(MAX_BASE);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_DIMS  = 0,
    CFG_RESULT_COUNT = 1
  } cfg_reg_t;

  typedef enum logic {
    ACT_QUERY = 1'b0,
    ACT_BASE  = 1'b1
  } action_t;

  // update request into the top-k list
  typedef struct packed {
    logic              clr;
    logic              ins;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dist_val;
  } topk_req_t;

  // full view of the list
  typedef struct packed {
    logic [K_MAX-1:0][ID_W-1:0]   ids;
    logic [K_MAX-1:0][DIST_W-1:0] dists;
    logic [CNT_W-1:0]             count;
  } topk_list_t;

endpackage

### src/el2tk_if.sv
// Channel interfaces of the search block: input items, results, config writes.
// Depends on el2tk_pkg.
interface el2tk_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [el2tk_pkg::VAL_W-1:0]  element_value;
  logic                                end_of_set;

  modport source (output valid, output action, output element_value, output end_of_set,
                  input ready);
  modport sink   (input valid, input action, input element_value, input end_of_set,
                  output ready);
endinterface

interface el2tk_out_if;
  logic                              valid;
  logic                              ready;
  logic [el2tk_pkg::ID_W-1:0]        neighbour_id;
  logic [el2tk_pkg::DIST_W-1:0]      distance;
  logic                              last_result;

  modport source (output valid, output neighbour_id, output distance, output last_result,
                  input ready);
  modport sink   (input valid, input neighbour_id, input distance, input last_result,
                  output ready);
endinterface

interface el2tk_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [el2tk_pkg::CFG_IDX_W-1:0]     index;
  logic [el2tk_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/el2tk_topk.sv
// Sorted top-k list with parallel insertion (ties keep older entry first).
// Depends on el2tk_pkg.
module el2tk_topk (
  input  logic                  clk,
  input  logic                  rst,
  input  el2tk_pkg::topk_req_t  req,
  output el2tk_pkg::topk_list_t list_next
);

  logic [el2tk_pkg::ID_W-1:0]   ids   [el2tk_pkg::K_MAX];
  logic [el2tk_pkg::DIST_W-1:0] dists [el2tk_pkg::K_MAX];
  logic [el2tk_pkg::CNT_W-1:0]  count;

  logic [el2tk_pkg::K_MAX-1:0] le;
  logic                        sorted_ok;

  // le is a prefix mask: entries that stay ahead of the new vector
  always_comb begin
    for (int i = 0; i < el2tk_pkg::K_MAX; i++) begin
      le[i] = (i < int'(count)) && (dists[i] <= req.dist_val);
    end
  end

  always_comb begin
    for (int i = 0; i < el2tk_pkg::K_MAX; i++) begin
      list_next.ids[i]   = ids[i];
      list_next.dists[i] = dists[i];
    end
    list_next.count = count;
    if (req.clr) begin
      list_next.count = '0;
    end else if (req.ins) begin
      for (int i = 0; i < el2tk_pkg::K_MAX; i++) begin
        if (!le[i]) begin
          if (i == 0) begin
            list_next.ids[i]   = req.id;
            list_next.dists[i] = req.dist_val;
          end else if (le[i-1]) begin
            list_next.ids[i]   = req.id;
            list_next.dists[i] = req.dist_val;
          end else begin
            list_next.ids[i]   = ids[i-1];
            list_next.dists[i] = dists[i-1];
          end
        end
      end
      if (count < el2tk_pkg::CNT_FULL) begin
        list_next.count = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= list_next.count;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < el2tk_pkg::K_MAX; i++) begin
      ids[i]   <= list_next.ids[i];
      dists[i] <= list_next.dists[i];
    end
  end

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < el2tk_pkg::K_MAX - 1; i++) begin
      if ((i + 1 < int'(count)) && (dists[i] > dists[i+1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= el2tk_pkg::CNT_FULL)
    else $error("top-k count above capacity");

  a_sorted: assert property (@(posedge clk) disable iff (rst) sorted_ok)
    else $error("top-k list out of order");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    req.clr |=> count == '0)
    else $error("list not cleared on new query");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    (req.ins && !req.clr && count < el2tk_pkg::CNT_FULL) |=> count == $past(count) + 1'b1)
    else $error("list did not grow on insertion");

endmodule

### src/exact_l2_topk_search_top.sv
// Exact k-nearest-neighbor search, squared L2 distance, top level.
// Depends on el2tk_pkg, el2tk_if and el2tk_topk.
//
// Channels: items (sink) carries query elements (action 0) and base vector
// elements (action 1), one dimension per request; results (source) carries
// neighbour_id/distance pairs nearest first, last_result on the final one;
// cfg (sink, always ready) writes vector_dims (index 0) and result_count
// (index 1), only while the block is idle: the user must ensure it, the block does not.
// Throughput: one element per cycle except during a stall. Each element passes a
// query-store read, a squaring stage, the 48-bit saturating accumulator, then
// the top-k list stage, which inserts a finished vector.
// Results: when the vector flagged end_of_set reaches the list stage, the list
// is copied into a snapshot buffer; results leave it at one per cycle while
// results.ready is high, so new elements keep flowing while the list drains.
// Stall: if a second end-of-set vector reaches the list stage while the
// previous list is still draining, items.ready drops until the buffer empties.
// Reset: vector_dims 128, result_count 10, list empty, counters zero. The
// query store is not cleared; load a query before streaming base vectors.
module exact_l2_topk_search_top (
  input logic           clk,
  input logic           rst,
  el2tk_in_if.sink      items,
  el2tk_out_if.source   results,
  el2tk_cfg_if.sink     cfg
);

  // configuration
  logic [el2tk_pkg::DIMS_W-1:0] vector_dims;
  logic [el2tk_pkg::K_W-1:0]    result_count;
  logic [el2tk_pkg::DIMS_W-1:0] dims_eff;
  logic [el2tk_pkg::K_W-1:0]    k_eff;

  // front end
  logic                          advance;
  logic                          take;
  logic [el2tk_pkg::POS_W-1:0]   dim_position;
  logic [el2tk_pkg::POS_CMP_W-1:0] pos_inc;
  logic                          vend;
  logic signed [el2tk_pkg::VAL_W-1:0] query_mem [el2tk_pkg::D_MAX];

  // stage 1: element and query value
  logic                               s1_valid;
  logic                               s1_base;
  logic                               s1_clr;
  logic                               s1_vend;
  logic                               s1_eos;
  logic signed [el2tk_pkg::VAL_W-1:0] s1_val;
  logic signed [el2tk_pkg::VAL_W-1:0] qdata;
  logic signed [el2tk_pkg::VAL_W:0]   diff;
  logic signed [2*el2tk_pkg::VAL_W+1:0] prod;

  // stage 2: squared difference
  logic                         s2_valid;
  logic                         s2_base;
  logic                         s2_clr;
  logic                         s2_vend;
  logic                         s2_eos;
  logic [el2tk_pkg::SQ_W-1:0]   s2_sq;
  logic [el2tk_pkg::DIST_W-1:0] acc;
  logic [el2tk_pkg::DIST_W:0]   acc_sum;
  logic [el2tk_pkg::DIST_W-1:0] acc_sat;

  // stage 3: finished vector
  logic                         s3_valid;
  logic                         s3_clr;
  logic                         s3_ins;
  logic                         s3_emit;
  logic [el2tk_pkg::DIST_W-1:0] s3_dist;
  logic                         fire;
  logic [el2tk_pkg::CTR_W-1:0]  base_ctr;
  logic                         room;

  el2tk_pkg::topk_req_t  topk_req;
  el2tk_pkg::topk_list_t list_next;

  // result buffer
  logic [el2tk_pkg::CNT_W-1:0]  out_left;
  logic [el2tk_pkg::CNT_W-1:0]  emit_n;
  logic [el2tk_pkg::ID_W-1:0]   out_ids   [el2tk_pkg::K_MAX];
  logic [el2tk_pkg::DIST_W-1:0] out_dists [el2tk_pkg::K_MAX];

  // ---------------- configuration ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_dims  <= el2tk_pkg::DIMS_RESET;
      result_count <= el2tk_pkg::K_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (el2tk_pkg::cfg_reg_t'(cfg.index))
        el2tk_pkg::CFG_VECTOR_DIMS:  vector_dims  <= cfg.data[el2tk_pkg::DIMS_W-1:0];
        el2tk_pkg::CFG_RESULT_COUNT: result_count <= cfg.data[el2tk_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vector_dims == '0) begin
      dims_eff = el2tk_pkg::DIMS_W'(1);
    end else if (vector_dims > el2tk_pkg::DIMS_MAX_C) begin
      dims_eff = el2tk_pkg::DIMS_MAX_C;
    end else begin
      dims_eff = vector_dims;
    end
    if (result_count == '0) begin
      k_eff = el2tk_pkg::K_W'(1);
    end else if (result_count > el2tk_pkg::K_MAX_C) begin
      k_eff = el2tk_pkg::K_MAX_C;
    end else begin
      k_eff = result_count;
    end
  end

  // ---------------- front end ----------------
  assign advance     = !(s3_valid && s3_emit && (out_left != '0));
  assign items.ready = advance;
  assign take        = items.valid && items.ready;

  assign pos_inc = el2tk_pkg::POS_CMP_W'(dim_position) + 1'b1;
  assign vend    = pos_inc >= el2tk_pkg::POS_CMP_W'(dims_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_position <= '0;
    end else if (take) begin
      dim_position <= vend ? '0 : pos_inc[el2tk_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take && (items.action == el2tk_pkg::ACT_QUERY)) begin
      query_mem[dim_position] <= items.element_value;
    end
    if (take) begin
      qdata <= query_mem[dim_position];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_base <= items.action == el2tk_pkg::ACT_BASE;
      s1_clr  <= (items.action == el2tk_pkg::ACT_QUERY) && (dim_position == '0);
      s1_vend <= vend;
      s1_eos  <= items.end_of_set;
      s1_val  <= items.element_value;
    end
  end

  // ---------------- squaring ----------------
  assign diff = {s1_val[el2tk_pkg::VAL_W-1], s1_val} - {qdata[el2tk_pkg::VAL_W-1], qdata};
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_base <= s1_base;
      s2_clr  <= s1_clr;
      s2_vend <= s1_vend;
      s2_eos  <= s1_eos;
      s2_sq   <= prod[el2tk_pkg::SQ_W-1:0];
    end
  end

  // ---------------- accumulate ----------------
  assign acc_sum = {1'b0, acc} + (el2tk_pkg::DIST_W + 1)'(s2_sq);
  assign acc_sat = acc_sum[el2tk_pkg::DIST_W] ? '1 : acc_sum[el2tk_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid && (s2_clr || (s2_base && s2_vend));
      if (s2_valid) begin
        if (s2_clr) begin
          acc <= '0;
        end else if (s2_base) begin
          acc <= s2_vend ? '0 : acc_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_clr  <= s2_clr;
      s3_ins  <= s2_base && s2_vend;
      s3_emit <= s2_base && s2_vend && s2_eos;
      s3_dist <= acc_sat;
    end
  end

  // ---------------- list stage ----------------
  assign fire = advance && s3_valid;
  assign room = base_ctr < el2tk_pkg::BASE_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_ctr <= '0;
    end else if (fire) begin
      if (s3_clr) begin
        base_ctr <= '0;
      end else if (s3_ins && room) begin
        base_ctr <= base_ctr + 1'b1;
      end
    end
  end

  always_comb begin
    topk_req.clr      = fire && s3_clr;
    topk_req.ins      = fire && s3_ins && room;
    topk_req.id       = base_ctr[el2tk_pkg::ID_W-1:0];
    topk_req.dist_val = s3_dist;
  end

  el2tk_topk u_topk (
    .clk       (clk),
    .rst       (rst),
    .req       (topk_req),
    .list_next (list_next)
  );

  // ---------------- result buffer ----------------
  assign emit_n = (list_next.count < el2tk_pkg::CNT_W'(k_eff)) ?
                  list_next.count : el2tk_pkg::CNT_W'(k_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_left <= '0;
    end else if (fire && s3_emit) begin
      out_left <= emit_n;
    end else if (results.valid && results.ready) begin
      out_left <= out_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s3_emit) begin
      for (int i = 0; i < el2tk_pkg::K_MAX; i++) begin
        out_ids[i]   <= list_next.ids[i];
        out_dists[i] <= list_next.dists[i];
      end
    end else if (results.valid && results.ready) begin
      for (int i = 0; i < el2tk_pkg::K_MAX - 1; i++) begin
        out_ids[i]   <= out_ids[i+1];
        out_dists[i] <= out_dists[i+1];
      end
    end
  end

  assign results.valid        = out_left != '0;
  assign results.neighbour_id = out_ids[0];
  assign results.distance     = out_dists[0];
  assign results.last_result  = out_left == el2tk_pkg::CNT_W'(1);

  // ---------------- checks ----------------
  a_stall_only_draining: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> results.valid)
    else $error("input stalled with no result pending");

  a_drain_within_k: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> out_left <= el2tk_pkg::CNT_W'(k_eff))
    else $error("more results pending than k");

  a_stall_holds_vector: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(s3_dist) && s3_valid && s3_emit)
    else $error("list stage lost a stalled vector");

  a_new_list_after_drain: assert property (@(posedge clk) disable iff (rst)
    (fire && s3_emit) |-> $past(out_left == '0) || (out_left == '0))
    else $error("result list overwritten while draining");

endmodule
